// ===== rtl/device_number_hash_map_assert.svh =====
// Assertion macros for the checker of the device number table.
// No dependencies; include by bare file name inside a module body.
`ifndef DEVICE_NUMBER_HASH_MAP_ASSERT_SVH
`define DEVICE_NUMBER_HASH_MAP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define DNHM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define DNHM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dnhm_pkg.sv =====
// Package for the device number table: sizes, operation codes, payload and row types.
// No dependencies; used by device_number_hash_map and dnhm_checker.
package dnhm_pkg;

    localparam int BUCKETS  = 8;
    localparam int WAYS     = 4;
    localparam int BUCKET_W = $clog2(BUCKETS);
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_W   = $clog2(WAYS + 1);
    localparam int KEY_W    = 16;
    localparam int VALUE_W  = 32;

    typedef enum logic [1:0] {
        FUNC_ENTER  = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_LOOKUP = 2'd2
    } t_func;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [1:0]         func;
        logic [KEY_W-1:0]   dev_key;
        logic [VALUE_W-1:0] object_value;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] object_out;
        logic               bucket_full;
    } t_out_item;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_entry;

    typedef t_entry [WAYS-1:0] t_row;

    typedef logic [255:0][BUCKET_W-1:0] t_bucket_lut;

    // Folded byte -> bucket, built at elaboration.
    function automatic t_bucket_lut build_bucket_lut();
        t_bucket_lut lut;
        for (int i = 0; i < 256; i++) begin
            lut[i] = BUCKET_W'(i % BUCKETS);
        end
        return lut;
    endfunction

    localparam t_bucket_lut BUCKET_LUT = build_bucket_lut();

    function automatic logic [BUCKET_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
        return BUCKET_LUT[key[15:8] ^ key[7:0]];
    endfunction

endpackage

// ===== rtl/dnhm_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module dnhm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/device_number_hash_map.sv =====
// Device number table: bucketed key/value store with enter, remove and lookup.
// Depends on dnhm_pkg and dnhm_ram.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+-----------------------------
//  in      | i_in_valid  | o_in_ready  | i_in_item  (t_in_item)
//  out     | o_out_valid | i_out_ready | o_out_item (t_out_item)
//
// Each operation reads the bucket row from RAM on the input transfer, then
// compares and writes it back in the compute state, before a new item is taken.
// Synchronous active-low reset clears all bucket fill counts at once.
// The result sits in an output register; a new item is taken while it waits,
// but the compute cycle holds until the output register is free.
module device_number_hash_map (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dnhm_pkg::t_in_item i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dnhm_pkg::t_out_item o_out_item
);
    import dnhm_pkg::*;

    t_state               r_state, n_state;
    logic [1:0]           r_func;
    logic [KEY_W-1:0]     r_key;
    logic [VALUE_W-1:0]   r_value;
    logic [BUCKET_W-1:0]  r_bucket;
    logic [FILL_W-1:0]    r_fill [BUCKETS];
    logic                 r_out_valid;
    t_out_item            r_out_item;

    logic                 in_xfer;
    logic                 exec_go;
    logic                 ram_we;
    logic [BUCKET_W-1:0]  ram_addr;
    t_row                 row_rd;
    t_row                 row_wr;
    logic [FILL_W-1:0]    fill;
    logic [FILL_W-1:0]    n_fill;
    logic                 fill_we;
    logic                 hit;
    logic [WAY_W-1:0]     hit_idx;
    t_out_item            n_out_item;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign exec_go    = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);
    assign ram_addr   = in_xfer ? bucket_of(i_in_item.dev_key) : r_bucket;
    assign fill       = r_fill[r_bucket];

    dnhm_ram #(
        .WIDTH ($bits(t_row)),
        .DEPTH (BUCKETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (in_xfer),
        .i_addr  (ram_addr),
        .i_wdata (row_wr),
        .o_rdata (row_rd)
    );

    // oldest valid match in the row
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if ((FILL_W'(w) < fill) && (row_rd[w].key == r_key)) begin
                hit     = 1'b1;
                hit_idx = WAY_W'(w);
            end
        end
    end

    always_comb begin
        row_wr     = row_rd;
        ram_we     = 1'b0;
        fill_we    = 1'b0;
        n_fill     = fill;
        n_out_item = '0;
        n_state    = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    n_state = ST_IDLE;
                    case (r_func)
                        FUNC_ENTER: begin
                            if (fill == FILL_W'(WAYS)) begin
                                n_out_item.bucket_full = 1'b1;
                            end else begin
                                for (int w = 0; w < WAYS; w++) begin
                                    if (FILL_W'(w) == fill) begin
                                        row_wr[w].key   = r_key;
                                        row_wr[w].value = r_value;
                                    end
                                end
                                ram_we  = 1'b1;
                                fill_we = 1'b1;
                                n_fill  = fill + 1'b1;
                            end
                        end
                        FUNC_REMOVE: begin
                            if (hit) begin
                                // shift younger entries down over the hole
                                for (int w = 0; w < WAYS - 1; w++) begin
                                    if (WAY_W'(w) >= hit_idx) begin
                                        row_wr[w] = row_rd[w + 1];
                                    end
                                end
                                ram_we           = 1'b1;
                                fill_we          = 1'b1;
                                n_fill           = fill - 1'b1;
                                n_out_item.found = 1'b1;
                            end
                        end
                        FUNC_LOOKUP: begin
                            if (hit) begin
                                n_out_item.found      = 1'b1;
                                n_out_item.object_out = row_rd[hit_idx].value;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int b = 0; b < BUCKETS; b++) begin
                r_fill[b] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (fill_we) begin
                r_fill[r_bucket] <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_func   <= i_in_item.func;
            r_key    <= i_in_item.dev_key;
            r_value  <= i_in_item.object_value;
            r_bucket <= bucket_of(i_in_item.dev_key);
        end
        if (exec_go) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
endmodule

// ===== rtl/dnhm_checker.sv =====
// Port-level checker for the device number table, bound to the top level.
// Depends on dnhm_pkg and device_number_hash_map_assert.svh.
module dnhm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input dnhm_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input dnhm_pkg::t_out_item o_out_item
);
    import dnhm_pkg::*;
    `include "device_number_hash_map_assert.svh"

    `DNHM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item), "output dropped or changed while stalled")
    `DNHM_ASSERT_NOW(a_full_excl, o_out_valid, !(o_out_item.found && o_out_item.bucket_full), "found and bucket_full both set")
    `DNHM_ASSERT_NOW(a_miss_zero, o_out_valid && !o_out_item.found, o_out_item.object_out == '0, "nonzero object on a miss")
    `DNHM_ASSERT_NEXT(a_busy_after_in, i_in_valid && o_in_ready, !o_in_ready, "input taken in the compute cycle")
endmodule

bind device_number_hash_map dnhm_checker u_dnhm_checker (.*);
